// ----- design/msfm_pkg.sv -----
// Package for the motor supply fault monitor: types, codes and reset values.
package msfm_pkg;

  // Default width of the debounce run counters
  localparam int RUN_WIDTH_DEFAULT = 8;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PINCH_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_RUNS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_RUNS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_RUNS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_RUNS  = 3'd7;

  // Register reset values
  localparam logic [15:0] PINCH_LIMIT_RST  = 16'd8000;
  localparam logic [15:0] HIGH_LIMIT_RST   = 16'd15000;
  localparam logic [15:0] LOW_LIMIT_RST    = 16'd100;
  localparam logic [15:0] VOLT_LIMIT_RST   = 16'd9000;
  localparam logic [7:0]  HIGH_RUNS_RST    = 8'd5;
  localparam logic [7:0]  LOW_RUNS_RST     = 8'd5;
  localparam logic [7:0]  VOLT_RUNS_RST    = 8'd10;
  localparam logic [7:0]  RECOVER_RUNS_RST = 8'd10;

  // Command codes
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_ZERO   = 2'd2;

  // Motor mode codes
  localparam logic [2:0] MODE_UNINIT      = 3'd0;
  localparam logic [2:0] MODE_IDLE        = 3'd1;
  localparam logic [2:0] MODE_MANUAL_UP   = 3'd2;
  localparam logic [2:0] MODE_MANUAL_DOWN = 3'd3;
  localparam logic [2:0] MODE_AUTO_UP     = 3'd4;
  localparam logic [2:0] MODE_AUTO_DOWN   = 3'd5;
  localparam logic [2:0] MODE_FAULT       = 3'd6;

  typedef struct packed {
    logic [15:0] pinch_current_limit;
    logic [15:0] high_current_limit;
    logic [15:0] low_current_limit;
    logic [15:0] low_voltage_limit;
    logic [7:0]  high_current_runs;
    logic [7:0]  low_current_runs;
    logic [7:0]  low_voltage_runs;
    logic [7:0]  voltage_recover_runs;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] current_sample;
    logic [15:0] voltage_sample;
    logic [2:0]  motor_mode;
  } item_t;

  typedef struct packed {
    logic       pinch_flag;
    logic       high_current_fault;
    logic       low_current_fault;
    logic       low_voltage_fault;
    logic       any_fault;
    logic [1:0] fault_total;
  } result_t;

endpackage

// ----- design/motor_supply_fault_monitor.sv -----
// An accepted item is held in the input register; its result is registered into
// the result buffer. Throughput: one item per cycle while in_stall is low; the
// counter update loads the flags together with the result register, and the
// two-entry result buffer absorbs out_stall. in_stall rises only when both result
// entries are full and the input register is occupied. Synchronous active-high
// rst clears all valid bits, run counters and fault flags, and loads the register reset values.
module motor_supply_fault_monitor #(
  parameter int RUN_WIDTH = msfm_pkg::RUN_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB-style configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msfm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [msfm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [msfm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  // Input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        command,
  input  logic [15:0]                       current_sample,
  input  logic [15:0]                       voltage_sample,
  input  logic [2:0]                        motor_mode,
  // Result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              pinch_flag,
  output logic                              high_current_fault,
  output logic                              low_current_fault,
  output logic                              low_voltage_fault,
  output logic                              any_fault,
  output logic [1:0]                        fault_total
);
  import msfm_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t core_result;
  result_t out_data;
  logic    fire;
  logic    buf_ready;

  assign item.command        = command;
  assign item.current_sample = current_sample;
  assign item.voltage_sample = voltage_sample;
  assign item.motor_mode     = motor_mode;

  msfm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  msfm_core #(
    .RUN_WIDTH (RUN_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item       (item),
    .cfg        (cfg),
    .down_ready (buf_ready),
    .fire       (fire),
    .result     (core_result)
  );

  msfm_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (core_result),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign pinch_flag         = out_data.pinch_flag;
  assign high_current_fault = out_data.high_current_fault;
  assign low_current_fault  = out_data.low_current_fault;
  assign low_voltage_fault  = out_data.low_voltage_fault;
  assign any_fault          = out_data.any_fault;
  assign fault_total        = out_data.fault_total;

endmodule

// ----- design/msfm_cfg.sv -----
// Configuration register file behind the APB-style port.
module msfm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msfm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [msfm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [msfm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output msfm_pkg::cfg_t                    cfg
);
  import msfm_pkg::*;

  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pinch_current_limit  <= PINCH_LIMIT_RST;
      cfg.high_current_limit   <= HIGH_LIMIT_RST;
      cfg.low_current_limit    <= LOW_LIMIT_RST;
      cfg.low_voltage_limit    <= VOLT_LIMIT_RST;
      cfg.high_current_runs    <= HIGH_RUNS_RST;
      cfg.low_current_runs     <= LOW_RUNS_RST;
      cfg.low_voltage_runs     <= VOLT_RUNS_RST;
      cfg.voltage_recover_runs <= RECOVER_RUNS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PINCH_LIMIT:  cfg.pinch_current_limit  <= pwdata[15:0];
        REG_HIGH_LIMIT:   cfg.high_current_limit   <= pwdata[15:0];
        REG_LOW_LIMIT:    cfg.low_current_limit    <= pwdata[15:0];
        REG_VOLT_LIMIT:   cfg.low_voltage_limit    <= pwdata[15:0];
        REG_HIGH_RUNS:    cfg.high_current_runs    <= pwdata[7:0];
        REG_LOW_RUNS:     cfg.low_current_runs     <= pwdata[7:0];
        REG_VOLT_RUNS:    cfg.low_voltage_runs     <= pwdata[7:0];
        REG_RECOVER_RUNS: cfg.voltage_recover_runs <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_PINCH_LIMIT:  prdata = {16'd0, cfg.pinch_current_limit};
      REG_HIGH_LIMIT:   prdata = {16'd0, cfg.high_current_limit};
      REG_LOW_LIMIT:    prdata = {16'd0, cfg.low_current_limit};
      REG_VOLT_LIMIT:   prdata = {16'd0, cfg.low_voltage_limit};
      REG_HIGH_RUNS:    prdata = {24'd0, cfg.high_current_runs};
      REG_LOW_RUNS:     prdata = {24'd0, cfg.low_current_runs};
      REG_VOLT_RUNS:    prdata = {24'd0, cfg.low_voltage_runs};
      REG_RECOVER_RUNS: prdata = {24'd0, cfg.voltage_recover_runs};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- design/msfm_core.sv -----
// Input register, debounce counters, fault flags and result logic.
module msfm_core #(
  parameter int RUN_WIDTH = msfm_pkg::RUN_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  msfm_pkg::item_t     item,
  input  msfm_pkg::cfg_t      cfg,
  input  logic                down_ready,
  output logic                fire,
  output msfm_pkg::result_t   result
);
  import msfm_pkg::*;

  localparam int CMP_W = (RUN_WIDTH > 8) ? RUN_WIDTH : 8;
  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  logic  s1_valid;
  item_t s1_item;
  logic  s1_advance;

  logic [RUN_WIDTH-1:0] hc_run, lc_run, lv_run, rec_run;
  logic [RUN_WIDTH-1:0] hc_run_next, lc_run_next, lv_run_next, rec_run_next;
  logic [RUN_WIDTH-1:0] hc_inc, lc_inc, lv_inc, rec_inc;
  logic hc_flag, lc_flag, lv_flag;
  logic hc_flag_next, lc_flag_next, lv_flag_next;
  logic moving_up, monitored, pinch;
  logic cur_high, cur_low, volt_low;

  // Input register: moves on whenever the result side can take the item
  assign s1_advance = !s1_valid || down_ready;
  assign in_stall   = !s1_advance;
  assign fire       = s1_valid && down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && in_valid) begin
      s1_item <= item;
    end
  end

  // Sample decode
  assign moving_up = (s1_item.motor_mode == MODE_MANUAL_UP) ||
                     (s1_item.motor_mode == MODE_AUTO_UP);
  assign monitored = (s1_item.motor_mode == MODE_MANUAL_UP)   ||
                     (s1_item.motor_mode == MODE_MANUAL_DOWN) ||
                     (s1_item.motor_mode == MODE_AUTO_UP)     ||
                     (s1_item.motor_mode == MODE_AUTO_DOWN);
  assign cur_high  = s1_item.current_sample > cfg.high_current_limit;
  assign cur_low   = s1_item.current_sample < cfg.low_current_limit;
  assign volt_low  = s1_item.voltage_sample < cfg.low_voltage_limit;
  assign pinch     = (s1_item.command == CMD_SAMPLE) && moving_up &&
                     (s1_item.current_sample > cfg.pinch_current_limit);

  // Saturating increments
  assign hc_inc  = (hc_run  == RUN_MAX) ? hc_run  : hc_run  + 1'b1;
  assign lc_inc  = (lc_run  == RUN_MAX) ? lc_run  : lc_run  + 1'b1;
  assign lv_inc  = (lv_run  == RUN_MAX) ? lv_run  : lv_run  + 1'b1;
  assign rec_inc = (rec_run == RUN_MAX) ? rec_run : rec_run + 1'b1;

  // Next state of counters and flags
  always_comb begin
    hc_run_next  = hc_run;
    lc_run_next  = lc_run;
    lv_run_next  = lv_run;
    rec_run_next = rec_run;
    hc_flag_next = hc_flag;
    lc_flag_next = lc_flag;
    lv_flag_next = lv_flag;
    case (s1_item.command)
      CMD_SAMPLE: begin
        // Current checks only while the motor moves
        if (!monitored) begin
          hc_run_next  = '0;
          lc_run_next  = '0;
          hc_flag_next = 1'b0;
          lc_flag_next = 1'b0;
        end else begin
          if (cur_high) begin
            hc_run_next  = hc_inc;
            hc_flag_next = hc_flag ||
                           (CMP_W'(hc_inc) >= CMP_W'(cfg.high_current_runs));
          end else begin
            hc_run_next  = '0;
            hc_flag_next = 1'b0;
          end
          if (cur_low) begin
            lc_run_next  = lc_inc;
            lc_flag_next = lc_flag ||
                           (CMP_W'(lc_inc) >= CMP_W'(cfg.low_current_runs));
          end else begin
            lc_run_next  = '0;
            lc_flag_next = 1'b0;
          end
        end
        // Voltage: debounce to set, separate recovery run to clear
        if (volt_low) begin
          lv_run_next  = lv_inc;
          rec_run_next = '0;
          lv_flag_next = lv_flag ||
                         (CMP_W'(lv_inc) >= CMP_W'(cfg.low_voltage_runs));
        end else begin
          rec_run_next = rec_inc;
          if (CMP_W'(rec_inc) >= CMP_W'(cfg.voltage_recover_runs)) begin
            lv_run_next  = '0;
            lv_flag_next = 1'b0;
          end
        end
      end
      CMD_CLEAR: begin
        hc_run_next  = '0;
        lc_run_next  = '0;
        lv_run_next  = '0;
        rec_run_next = '0;
        hc_flag_next = 1'b0;
        lc_flag_next = 1'b0;
        lv_flag_next = 1'b0;
      end
      CMD_ZERO: begin
        hc_run_next  = '0;
        lc_run_next  = '0;
        lv_run_next  = '0;
        rec_run_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hc_run  <= '0;
      lc_run  <= '0;
      lv_run  <= '0;
      rec_run <= '0;
      hc_flag <= 1'b0;
      lc_flag <= 1'b0;
      lv_flag <= 1'b0;
    end else if (fire) begin
      hc_run  <= hc_run_next;
      lc_run  <= lc_run_next;
      lv_run  <= lv_run_next;
      rec_run <= rec_run_next;
      hc_flag <= hc_flag_next;
      lc_flag <= lc_flag_next;
      lv_flag <= lv_flag_next;
    end
  end

  // Result of this item
  always_comb begin
    result.pinch_flag         = pinch;
    result.high_current_fault = hc_flag_next;
    result.low_current_fault  = lc_flag_next;
    result.low_voltage_fault  = lv_flag_next;
    result.any_fault          = hc_flag_next || lc_flag_next || lv_flag_next;
    result.fault_total        = {1'b0, hc_flag_next} + {1'b0, lc_flag_next} +
                                {1'b0, lv_flag_next};
  end

  // A clear item drops every flag and the voltage and recovery run counters
  a_clear_drops: assert property (@(posedge clk) disable iff (rst)
    fire && (s1_item.command == CMD_CLEAR) |=>
      !hc_flag && !lc_flag && !lv_flag && (lv_run == '0) && (rec_run == '0))
    else $error("clear item left a flag or counter set");

  // A stopped motor zeroes the current debounce
  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    fire && (s1_item.command == CMD_SAMPLE) && !monitored |=>
      (hc_run == '0) && (lc_run == '0) && !hc_flag && !lc_flag)
    else $error("current debounce kept while motor not moving");

endmodule

// ----- design/msfm_outbuf.sv -----
// Result register with a skid entry so the input side waits on out_stall only when the skid entry is full.
module msfm_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  msfm_pkg::result_t   push_data,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output msfm_pkg::result_t   out_data
);
  import msfm_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign ready     = !skid_valid;
  assign out_valid = main_valid;
  assign pop       = main_valid && !out_stall;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  // The skid entry is only filled behind a waiting result
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry holds an item with the output empty");

  // Draining the output with a full skid refills it
  a_skid_refill: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> main_valid && !skid_valid)
    else $error("skid item lost on drain");

endmodule
